### rtl/pts_pkg.sv
package pts_pkg;

   localparam int THREAD_SLOTS = 16;
   localparam int TID_W       = 4;
   localparam int CNT_W       = 5;
   localparam int PRIO_W      = 3;
   localparam int VAL_W       = 32;
   localparam logic [PRIO_W-1:0] PRIO_MAX  = 3'd5;
   localparam logic [PRIO_W-1:0] MAIN_PRIO = 3'd3;

   typedef enum logic [2:0] {
      KIND_CREATE = 3'd0,
      KIND_YIELD  = 3'd1,
      KIND_JOIN   = 3'd2,
      KIND_FINISH = 3'd3,
      KIND_TICK   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      TS_READY = 2'd0,
      TS_RUN   = 2'd1,
      TS_WAIT  = 2'd2,
      TS_DONE  = 2'd3
   } thread_state_type;

   typedef enum logic [1:0] {
      RSP_DONE    = 2'd0,
      RSP_ERROR   = 2'd1,
      RSP_BLOCKED = 2'd2,
      RSP_EMPTY   = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      RD_RUN  = 2'd0,
      RD_TGT  = 2'd1,
      RD_SCAN = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE       = 3'd0,
      S_DECODE     = 3'd1,
      S_HEAD_SCAN  = 3'd2,
      S_WAKE_SCAN  = 3'd3,
      S_WAKE_APPLY = 3'd4,
      S_EXEC       = 3'd5
   } ctl_state_type;

   typedef struct packed {
      logic       load;
      logic       decode;
      logic       mark_done;
      logic       scan_step;
      logic       scan_wake;
      logic       wake;
      logic       exec;
      rd_sel_type rd_sel;
   } ctl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     idle;
      logic     join_bad;
      logic     join_done;
      logic     found;
      logic     scan_last;
      logic     out_free;
   } dp_sts_type;

   function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
      return (p > PRIO_MAX) ? PRIO_MAX : p;
   endfunction

endpackage

### rtl/pts_ram.sv
module pts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/pts_ctl.sv
module pts_ctl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pts_pkg::dp_sts_type sts,
   output pts_pkg::ctl_cmd_type cmd
);
   import pts_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (sts.kind)
               KIND_YIELD, KIND_TICK: state_in = S_HEAD_SCAN;
               KIND_JOIN: begin
                  state_in = (sts.join_bad || sts.join_done) ? S_EXEC : S_HEAD_SCAN;
               end
               KIND_FINISH: state_in = sts.idle ? S_EXEC : S_WAKE_SCAN;
               default: state_in = S_EXEC;
            endcase
         end
         S_HEAD_SCAN: begin
            if (sts.scan_last) state_in = S_EXEC;
         end
         S_WAKE_SCAN: begin
            if (sts.scan_last) state_in = S_WAKE_APPLY;
         end
         S_WAKE_APPLY: begin
            state_in = sts.found ? S_WAKE_SCAN : S_HEAD_SCAN;
         end
         S_EXEC: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_RUN;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_DECODE: begin
            cmd.rd_sel    = RD_TGT;
            cmd.decode    = 1'b1;
            cmd.mark_done = (sts.kind == KIND_FINISH) && !sts.idle;
         end
         S_HEAD_SCAN: begin
            cmd.rd_sel    = RD_SCAN;
            cmd.scan_step = 1'b1;
         end
         S_WAKE_SCAN: begin
            cmd.rd_sel    = RD_SCAN;
            cmd.scan_step = 1'b1;
            cmd.scan_wake = 1'b1;
         end
         S_WAKE_APPLY: begin
            cmd.wake = sts.found;
         end
         S_EXEC: begin
            cmd.exec = sts.out_free;
         end
         default: ;
      endcase
   end

endmodule

### rtl/pts_dp.sv
module pts_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  pts_pkg::ctl_cmd_type cmd,
   output pts_pkg::dp_sts_type  sts,
   input  logic [47:0]          req_tdata,
   input  logic                 csr_we,
   input  logic [2:0]           csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata
);
   import pts_pkg::*;

   // thread table
   logic                    valid_ff [THREAD_SLOTS];
   logic                    valid_in [THREAD_SLOTS];
   thread_state_type        tstate_ff [THREAD_SLOTS];
   thread_state_type        tstate_in [THREAD_SLOTS];
   logic [PRIO_W-1:0]       prio_ff [THREAD_SLOTS];
   logic [PRIO_W-1:0]       prio_in [THREAD_SLOTS];
   logic [TID_W-1:0]        wait_ff [THREAD_SLOTS];
   logic [TID_W-1:0]        wait_in [THREAD_SLOTS];
   logic [THREAD_SLOTS-1:0] order_ff [THREAD_SLOTS];
   logic [THREAD_SLOTS-1:0] order_in [THREAD_SLOTS];

   logic [TID_W-1:0] running_ff, running_in;
   logic [CNT_W-1:0] next_free_ff, next_free_in;

   // current item
   logic [2:0]        kind_ff;
   logic [PRIO_W-1:0] preq_ff;
   logic [TID_W-1:0]  tgt_ff;
   logic [VAL_W-1:0]  value_ff;
   logic              idle_ff, join_bad_ff, join_done_ff;

   // scan
   logic [TID_W-1:0]  idx_ff, idx_in;
   logic [TID_W-1:0]  best_ff, best_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic              found_ff, found_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;

   logic [TID_W-1:0]  rd_addr;
   logic              rd_valid;
   thread_state_type  rd_state;
   logic [PRIO_W-1:0] rd_prio;
   logic [TID_W-1:0]  rd_wait;
   logic [THREAD_SLOTS-1:0] rd_order;
   logic [VAL_W-1:0]  ram_rd;

   logic              scan_first, scan_last, cand, better, older_best;
   logic              join_bad;

   rsp_status_type    ex_status;
   logic              ex_sw;
   logic [TID_W-1:0]  ex_new;
   logic [VAL_W-1:0]  ex_rv;
   logic              do_start, do_requeue, do_block, do_create;
   logic              stamp_en;
   logic [TID_W-1:0]  stamp_id;
   logic [TID_W-1:0]  new_id;

   assign new_id = next_free_ff[TID_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_RUN:  rd_addr = running_ff;
         RD_TGT:  rd_addr = tgt_ff;
         RD_SCAN: rd_addr = idx_ff;
         default: rd_addr = running_ff;
      endcase
   end

   assign rd_valid = valid_ff[rd_addr];
   assign rd_state = tstate_ff[rd_addr];
   assign rd_prio  = prio_ff[rd_addr];
   assign rd_wait  = wait_ff[rd_addr];
   assign rd_order = order_ff[rd_addr];

   pts_ram #(.WIDTH(VAL_W), .DEPTH(THREAD_SLOTS)) u_result (
      .clock   (clock),
      .wr_en   (cmd.mark_done),
      .wr_addr (running_ff),
      .wr_data (value_ff),
      .rd_addr (tgt_ff),
      .rd_data (ram_rd)
   );

   // one entry per cycle; the best candidate so far is held in best_ff
   assign scan_first = (idx_ff == '0);
   assign scan_last  = (idx_ff == TID_W'(THREAD_SLOTS - 1));
   assign older_best = rd_order[best_ff];
   assign cand = rd_valid && (cmd.scan_wake ?
                 (rd_state == TS_WAIT && rd_wait == running_ff) : (rd_state == TS_READY));
   assign better = scan_first || !found_ff || (cmd.scan_wake ? older_best :
                   (rd_prio < best_prio_ff || (rd_prio == best_prio_ff && older_best)));

   always_comb begin
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      found_in     = found_ff;
      if (cmd.scan_step) begin
         idx_in = scan_last ? '0 : idx_ff + 1'b1;
         if (cand && better) begin
            best_in      = idx_ff;
            best_prio_in = rd_prio;
            found_in     = 1'b1;
         end else if (scan_first) begin
            found_in = 1'b0;
         end
      end
   end

   assign join_bad = idle_ff || !rd_valid || (tgt_ff == running_ff);

   // apply the item; rd port points at the running thread here
   always_comb begin
      ex_status  = RSP_DONE;
      ex_new     = '0;
      ex_rv      = '0;
      do_start   = 1'b0;
      do_requeue = 1'b0;
      do_block   = 1'b0;
      do_create  = 1'b0;
      case (kind_type'(kind_ff))
         KIND_CREATE: begin
            if (next_free_ff >= CNT_W'(THREAD_SLOTS)) begin
               ex_status = RSP_ERROR;
            end else begin
               do_create = 1'b1;
               ex_new    = new_id;
            end
         end
         KIND_YIELD, KIND_TICK: begin
            if (!found_ff) begin
               ex_status = RSP_EMPTY;
            end else if (idle_ff) begin
               do_start = 1'b1;
            end else if (kind_ff == KIND_YIELD || best_prio_ff <= rd_prio) begin
               do_start   = 1'b1;
               do_requeue = 1'b1;
            end
         end
         KIND_JOIN: begin
            if (join_bad_ff) begin
               ex_status = RSP_ERROR;
            end else if (join_done_ff) begin
               ex_rv = ram_rd;
            end else if (!found_ff) begin
               ex_status = RSP_EMPTY;
            end else begin
               ex_status = RSP_BLOCKED;
               do_block  = 1'b1;
               do_start  = 1'b1;
            end
         end
         KIND_FINISH: begin
            if (idle_ff) begin
               ex_status = RSP_ERROR;
            end else if (!found_ff) begin
               ex_status = RSP_EMPTY;
            end else begin
               do_start = 1'b1;
            end
         end
         default: ex_status = RSP_ERROR;
      endcase
      ex_sw = do_start;
   end

   always_comb begin
      stamp_en = 1'b0;
      stamp_id = running_ff;
      if (cmd.wake) begin
         stamp_en = 1'b1;
         stamp_id = best_ff;
      end else if (cmd.exec && do_create) begin
         stamp_en = 1'b1;
         stamp_id = new_id;
      end else if (cmd.exec && (do_requeue || do_block)) begin
         stamp_en = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         valid_in[i]  = valid_ff[i];
         tstate_in[i] = tstate_ff[i];
         prio_in[i]   = prio_ff[i];
         wait_in[i]   = wait_ff[i];
         order_in[i]  = order_ff[i];
         if (cmd.mark_done && running_ff == TID_W'(i)) tstate_in[i] = TS_DONE;
         if (cmd.wake && best_ff == TID_W'(i)) tstate_in[i] = TS_READY;
         if (cmd.exec) begin
            if (do_create && new_id == TID_W'(i)) begin
               valid_in[i]  = 1'b1;
               tstate_in[i] = TS_READY;
               prio_in[i]   = clamp_prio(preq_ff);
               wait_in[i]   = '0;
            end
            if (running_ff == TID_W'(i)) begin
               if (do_requeue) tstate_in[i] = TS_READY;
               if (do_block) begin
                  tstate_in[i] = TS_WAIT;
                  wait_in[i]   = tgt_ff;
               end
            end
            if (do_start && best_ff == TID_W'(i)) tstate_in[i] = TS_RUN;
         end
         if (csr_we && i == 0) prio_in[i] = clamp_prio(csr_wdata);
         // mark the stamped entry youngest
         if (stamp_en) begin
            order_in[i][stamp_id] = 1'b1;
            if (stamp_id == TID_W'(i)) order_in[i] = '0;
         end
      end
   end

   assign running_in   = (cmd.exec && do_start) ? best_ff : running_ff;
   assign next_free_in = (cmd.exec && do_create) ? next_free_ff + 1'b1 : next_free_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, ex_rv, ex_new, ex_sw, running_in, ex_status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            valid_ff[i]  <= (i == 0);
            tstate_ff[i] <= (i == 0) ? TS_RUN : TS_READY;
            prio_ff[i]   <= (i == 0) ? MAIN_PRIO : '0;
            wait_ff[i]   <= '0;
            order_ff[i]  <= '0;
         end
         running_ff   <= '0;
         next_free_ff <= CNT_W'(1);
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            valid_ff[i]  <= valid_in[i];
            tstate_ff[i] <= tstate_in[i];
            prio_ff[i]   <= prio_in[i];
            wait_ff[i]   <= wait_in[i];
            order_ff[i]  <= order_in[i];
         end
         running_ff   <= running_in;
         next_free_ff <= next_free_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      rsp_data_ff  <= rsp_data_in;
      if (cmd.load) begin
         kind_ff  <= req_tdata[2:0];
         preq_ff  <= req_tdata[5:3];
         tgt_ff   <= req_tdata[9:6];
         value_ff <= req_tdata[41:10];
         idle_ff  <= (rd_state == TS_DONE);
      end
      if (cmd.decode) begin
         join_bad_ff  <= join_bad;
         join_done_ff <= (rd_state == TS_DONE);
      end
   end

   assign sts.kind      = kind_type'(kind_ff);
   assign sts.idle      = idle_ff;
   assign sts.join_bad  = join_bad;
   assign sts.join_done = (rd_state == TS_DONE);
   assign sts.found     = found_ff;
   assign sts.scan_last = scan_last;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/priority_thread_scheduler_unit.sv
// Hardware thread scheduler for up to 16 threads.
// req channel: one scheduler event per item (create, yield, join, finish,
//   tick). req_tready is high only while no event is in progress.
// rsp channel: exactly one result item per event, held in an output register.
// csr port: csr_we writes main_priority (thread zero's priority) at once;
//   write only while the block is idle.
// Sequence: create, a completed join and any error go from decode straight to
//   the apply step; yield, tick and a blocking join first scan the whole
//   thread table for the ready head; finish repeats a wake scan of the table
//   plus an apply step, waking one waiter each time, until none is found,
//   then does the head scan. The table scan visits one entry per cycle
//   through a single read port.
// Reset: thread zero runs with priority 3, no other thread exists, the
//   result register is empty.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next event is still taken, and its result waits until that slot frees.
module priority_thread_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0], priority_req[5:3], target_tid[9:6], value[41:10], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], running_tid[5:2], switched[6], new_tid[10:7],
   // ret_value[42:11], zero fill
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);
   import pts_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequence the event: decode, table scans, wake loop, apply
   pts_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // thread table, scan unit, result store and output register
   pts_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
